>>> hw/rtl/wsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsu_pkg
// Shared codes and types of the WebSocket unmasker: input, stage and result.
// ----------------------------------------------------------------------------
package wsu_pkg;

  // Length codes in the 7-bit length field of header byte 1.
  localparam logic [6:0] LEN_EXT16 = 7'd126;  // 16-bit extended length follows
  localparam logic [6:0] LEN_EXT64 = 7'd127;  // 64-bit length, not supported

  // One received byte of the frame stream.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_end;
  } wsu_in_t;

  // One result item.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       last_of_frame;
    logic       empty_payload;
    logic       unsupported_length;
  } wsu_out_t;

  // Input register contents handed to the parser.
  typedef struct packed {
    logic    valid;
    wsu_in_t item;
  } wsu_stage_t;

endpackage
`default_nettype wire

>>> hw/rtl/wsu_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsu_in_reg
// Input register: captures one byte per cycle while the pipeline advances.
// ----------------------------------------------------------------------------
module wsu_in_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              advance_i,
  input  wire logic              in_valid_i,
  input  wire wsu_pkg::wsu_in_t  in_data_i,
  output wsu_pkg::wsu_stage_t    stage_o
);
  import wsu_pkg::*;

  logic    valid_q;
  wsu_in_t item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= in_valid_i;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (advance_i && in_valid_i) begin
      item_q <= in_data_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule
`default_nettype wire

>>> hw/rtl/wsu_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsu_parser
// Header state machine and payload unmask; one byte per step.
// ----------------------------------------------------------------------------
module wsu_parser (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                advance_i,
  input  wire wsu_pkg::wsu_stage_t stage_i,
  output logic                     res_valid_o,
  output wsu_pkg::wsu_out_t        res_o
);
  import wsu_pkg::*;

  localparam logic [2:0] PH_BYTE0   = 3'd0;
  localparam logic [2:0] PH_BYTE1   = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_DISCARD = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_q, mask_d;
  logic [15:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  hbc_q, hbc_d;
  logic [1:0]  pidx_q, pidx_d;

  logic       step;
  logic [7:0] b;
  logic       ce;
  logic [1:0] hbc_inc;
  logic       end_empty;
  logic       emit_unsup;
  logic       emit_data;
  logic       data_last;
  logic [7:0] data_byte;

  assign step    = advance_i && stage_i.valid;
  assign b       = stage_i.item.rx_byte;
  assign ce      = stage_i.item.chunk_end;
  assign hbc_inc = hbc_q + 2'd1;

  always_comb begin
    phase_d    = phase_q;
    opcode_d   = opcode_q;
    mask_d     = mask_q;
    rem_d      = rem_q;
    key_d      = key_q;
    hbc_d      = hbc_q;
    pidx_d     = pidx_q;
    end_empty  = 1'b0;
    emit_unsup = 1'b0;
    emit_data  = 1'b0;
    data_last  = 1'b0;
    data_byte  = b;

    unique case (phase_q)
      PH_BYTE1: begin
        mask_d = b[7];
        hbc_d  = 2'd0;
        if (b[6:0] == LEN_EXT64) begin
          phase_d    = ce ? PH_BYTE0 : PH_DISCARD;
          emit_unsup = 1'b1;
        end else if (b[6:0] == LEN_EXT16) begin
          rem_d = 16'd0;
          if (ce) begin
            end_empty = 1'b1;
          end else begin
            phase_d = PH_EXTLEN;
          end
        end else begin
          rem_d = {9'd0, b[6:0]};
          if (b[7]) begin
            if (ce) begin
              end_empty = 1'b1;
            end else begin
              phase_d = PH_KEY;
            end
          end else if (b[6:0] == 7'd0 || ce) begin
            end_empty = 1'b1;
          end else begin
            phase_d = PH_PAYLOAD;
            pidx_d  = 2'd0;
          end
        end
      end
      PH_EXTLEN: begin
        rem_d = {rem_q[7:0], b};
        if (hbc_inc[1]) begin
          hbc_d = 2'd0;
          if (mask_q) begin
            if (ce) begin
              end_empty = 1'b1;
            end else begin
              phase_d = PH_KEY;
            end
          end else if (rem_d == 16'd0 || ce) begin
            end_empty = 1'b1;
          end else begin
            phase_d = PH_PAYLOAD;
            pidx_d  = 2'd0;
          end
        end else begin
          hbc_d = hbc_inc;
          if (ce) begin
            end_empty = 1'b1;
          end
        end
      end
      PH_KEY: begin
        key_d[{hbc_q, 3'b000} +: 8] = key_q[{hbc_q, 3'b000} +: 8] | b;
        if (hbc_q == 2'd3) begin
          hbc_d = 2'd0;
          if (rem_q == 16'd0 || ce) begin
            end_empty = 1'b1;
          end else begin
            phase_d = PH_PAYLOAD;
            pidx_d  = 2'd0;
          end
        end else begin
          hbc_d = hbc_inc;
          if (ce) begin
            end_empty = 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        data_byte = mask_q ? (b ^ key_q[{pidx_q, 3'b000} +: 8]) : b;
        pidx_d    = pidx_q + 2'd1;
        rem_d     = rem_q - 16'd1;
        data_last = (rem_d == 16'd0) || ce;
        emit_data = 1'b1;
        if (data_last) begin
          phase_d = PH_BYTE0;
        end
      end
      PH_DISCARD: begin
        if (ce) begin
          phase_d = PH_BYTE0;
        end
      end
      default: begin
        // byte 0; unused phase codes land here too
        opcode_d = b[3:0];
        mask_d   = 1'b0;
        rem_d    = 16'd0;
        key_d    = 32'd0;
        hbc_d    = 2'd0;
        pidx_d   = 2'd0;
        if (ce) begin
          end_empty = 1'b1;
        end else begin
          phase_d = PH_BYTE1;
        end
      end
    endcase

    if (end_empty) begin
      phase_d = PH_BYTE0;
      hbc_d   = 2'd0;
    end
  end

  always_comb begin
    res_valid_o              = stage_i.valid && (end_empty || emit_unsup || emit_data);
    res_o.frame_opcode       = opcode_d;
    res_o.payload_byte       = emit_data ? data_byte : 8'd0;
    res_o.last_of_frame      = emit_data ? data_last : 1'b1;
    res_o.empty_payload      = !emit_data;
    res_o.unsupported_length = emit_unsup;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_BYTE0;
      opcode_q <= 4'd0;
      mask_q   <= 1'b0;
      rem_q    <= 16'd0;
      key_q    <= 32'd0;
      hbc_q    <= 2'd0;
      pidx_q   <= 2'd0;
    end else if (step) begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      rem_q    <= rem_d;
      key_q    <= key_d;
      hbc_q    <= hbc_d;
      pidx_q   <= pidx_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/wsu_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsu_out_reg
// Result register: holds a result until the downstream side takes it.
// ----------------------------------------------------------------------------
module wsu_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              res_valid_i,
  input  wire wsu_pkg::wsu_out_t res_i,
  input  wire logic              out_stall_i,
  output logic                   advance_o,
  output logic                   out_valid_o,
  output wsu_pkg::wsu_out_t      out_data_o
);
  import wsu_pkg::*;

  logic     valid_q;
  wsu_out_t data_q;

  // the whole pipe moves whenever the result register is free or being drained
  assign advance_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
`default_nettype wire

>>> hw/rtl/websocket_frame_unmasker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_unmasker
// Byte-wide WebSocket frame deframer: decodes the header and emits unmasked
// payload bytes, with marker results for empty, aborted or unsupported frames.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake            | Payload   | Transaction
//  ---------+----------------------+-----------+-----------------------------
//  in       | in_valid_i/in_stall_o  | in_data_i  | one received byte
//  out      | out_valid_o/out_stall_i| out_data_o | zero or one result per byte
//
//  One byte per cycle while the output does not stall. An input transaction
//  passes the input register, then the header state machine and XOR feeding
//  the result register.
//  Reset (asynchronous, active low) returns the parser to waiting for byte 0.
//  A stall on the output freezes both stages; in_stall_o follows it only
//  while the result register is occupied.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire wsu_pkg::wsu_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output wsu_pkg::wsu_out_t      out_data_o
);
  import wsu_pkg::*;

  logic       advance;
  wsu_stage_t stage;
  logic       res_valid;
  wsu_out_t   res;

  // global pipeline enable, driven by the result register
  assign in_stall_o = !advance;

  wsu_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .stage_o    (stage)
  );

  // state updates only when the registered byte moves on
  wsu_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .stage_i     (stage),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsu_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
